FILE: rtl/secc_pkg.sv
// Shared types, constants and edge decode for the shared edge crease classifier.
// Depends on nothing; used by secc_edge_match and the top level.
`timescale 1ns / 1ps

package secc_pkg;

  // Width of every packed input field.
  localparam int unsigned FIELD_W = 48;

  // Crease limit register: unsigned squared distance.
  localparam int unsigned LIMIT_W = 34;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 34'd287708054;

  // Configuration port.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 64;

  typedef enum logic [0:0] {
    REG_CREASE_LIMIT_SQ = 1'b0
  } reg_idx_e;

  typedef enum logic [1:0] {
    EDGE_01 = 2'd0,
    EDGE_12 = 2'd1,
    EDGE_02 = 2'd2
  } edge_idx_e;

  typedef struct packed {
    logic      valid;
    edge_idx_e code;
  } edge_dec_t;

  typedef struct packed {
    logic      shared;
    edge_idx_e cur_edge;
    edge_idx_e oth_edge;
  } match_t;

  // Map a set of two vertex positions to an edge code.
  function automatic edge_dec_t edge_from_mask(logic [2:0] mask);
    edge_dec_t dec;
    dec.valid = 1'b0;
    dec.code  = EDGE_01;
    case (mask)
      3'b011: begin
        dec.valid = 1'b1;
        dec.code  = EDGE_01;
      end
      3'b110: begin
        dec.valid = 1'b1;
        dec.code  = EDGE_12;
      end
      3'b101: begin
        dec.valid = 1'b1;
        dec.code  = EDGE_02;
      end
      default: begin
        dec.valid = 1'b0;
        dec.code  = EDGE_01;
      end
    endcase
    return dec;
  endfunction

endpackage

FILE: rtl/shared_edge_crease_classifier.sv
// An accepted item passes through the stages below to its result on the output registers.
// Throughput: one item per cycle while out_stall_i does not hold the pipe; stages: input register,
// match/square register, result register. The compare of the summed squares against the limit sets the last stage.
// Reset clears all valid flags and loads the crease limit with its default.
// Depends on secc_pkg and secc_edge_match.
`timescale 1ns / 1ps

module shared_edge_crease_classifier #(
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned NORMAL_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [secc_pkg::PADDR_W-1:0]  paddr,
  input  logic [secc_pkg::PDATA_W-1:0]  pwdata,
  output logic [secc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [secc_pkg::FIELD_W-1:0]  cur_vertex_a_i,
  input  logic [secc_pkg::FIELD_W-1:0]  cur_vertex_b_i,
  input  logic [secc_pkg::FIELD_W-1:0]  cur_vertex_c_i,
  input  logic [secc_pkg::FIELD_W-1:0]  oth_vertex_a_i,
  input  logic [secc_pkg::FIELD_W-1:0]  oth_vertex_b_i,
  input  logic [secc_pkg::FIELD_W-1:0]  oth_vertex_c_i,
  input  logic [secc_pkg::FIELD_W-1:0]  cur_unit_normal_i,
  input  logic [secc_pkg::FIELD_W-1:0]  oth_unit_normal_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          edge_shared_o,
  output logic [1:0]                    cur_edge_index_o,
  output logic [1:0]                    oth_edge_index_o,
  output logic                          cur_edge_keep_o,
  output logic                          oth_edge_clear_o
);

  localparam int unsigned NPAD_W =
    (3 * NORMAL_BITS > secc_pkg::FIELD_W) ? 3 * NORMAL_BITS : secc_pkg::FIELD_W;
  localparam int unsigned DIFF_W = NORMAL_BITS + 1;
  localparam int unsigned SQ_W   = 2 * NORMAL_BITS;
  localparam int unsigned DIST_W = SQ_W + 2;
  localparam int unsigned CMP_W  =
    (DIST_W > secc_pkg::LIMIT_W) ? DIST_W : secc_pkg::LIMIT_W;

  // ---------------- configuration ----------------
  logic [secc_pkg::LIMIT_W-1:0] limit_q;
  logic [secc_pkg::LIMIT_W-1:0] limit_d;
  secc_pkg::reg_idx_e           reg_idx;
  logic                         cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = secc_pkg::reg_idx_e'(paddr[secc_pkg::PADDR_W-1]);
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    limit_d = limit_q;
    prdata  = '0;
    case (reg_idx)
      secc_pkg::REG_CREASE_LIMIT_SQ: begin
        prdata = {{(secc_pkg::PDATA_W - secc_pkg::LIMIT_W){1'b0}}, limit_q};
        if (cfg_write) begin
          limit_d = pwdata[secc_pkg::LIMIT_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= secc_pkg::LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  // ---------------- flow control ----------------
  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_ready, b_ready, c_ready;

  assign c_ready    = ~c_valid_q | ~out_stall_i;
  assign b_ready    = ~b_valid_q | c_ready;
  assign a_ready    = ~a_valid_q | b_ready;
  assign in_stall_o = ~a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  // ---------------- stage A: input register ----------------
  logic [secc_pkg::FIELD_W-1:0] a_cur_v_q [3];
  logic [secc_pkg::FIELD_W-1:0] a_oth_v_q [3];
  logic [secc_pkg::FIELD_W-1:0] a_cur_n_q;
  logic [secc_pkg::FIELD_W-1:0] a_oth_n_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) begin
      a_cur_v_q[0] <= cur_vertex_a_i;
      a_cur_v_q[1] <= cur_vertex_b_i;
      a_cur_v_q[2] <= cur_vertex_c_i;
      a_oth_v_q[0] <= oth_vertex_a_i;
      a_oth_v_q[1] <= oth_vertex_b_i;
      a_oth_v_q[2] <= oth_vertex_c_i;
      a_cur_n_q    <= cur_unit_normal_i;
      a_oth_n_q    <= oth_unit_normal_i;
    end
  end

  // ---------------- stage B: match and squares ----------------
  secc_pkg::match_t a_match;
  logic [NPAD_W-1:0] cur_npad;
  logic [NPAD_W-1:0] oth_npad;
  logic [SQ_W-1:0]   sq_d [3];

  secc_edge_match #(
    .COORD_BITS(COORD_BITS)
  ) u_match (
    .cur_v0_i (a_cur_v_q[0]),
    .cur_v1_i (a_cur_v_q[1]),
    .cur_v2_i (a_cur_v_q[2]),
    .oth_v0_i (a_oth_v_q[0]),
    .oth_v1_i (a_oth_v_q[1]),
    .oth_v2_i (a_oth_v_q[2]),
    .match_o  (a_match)
  );

  assign cur_npad = NPAD_W'(a_cur_n_q);
  assign oth_npad = NPAD_W'(a_oth_n_q);

  always_comb begin
    logic signed [DIFF_W-1:0]   diff;
    logic signed [2*DIFF_W-1:0] prod;
    for (int k = 0; k < 3; k++) begin
      diff = DIFF_W'($signed(cur_npad[k*NORMAL_BITS +: NORMAL_BITS]))
           - DIFF_W'($signed(oth_npad[k*NORMAL_BITS +: NORMAL_BITS]));
      prod = diff * diff;
      sq_d[k] = prod[SQ_W-1:0];
    end
  end

  secc_pkg::match_t b_match_q;
  logic [SQ_W-1:0]  b_sq_q [3];

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_ready) begin
      b_match_q <= a_match;
      b_sq_q[0] <= sq_d[0];
      b_sq_q[1] <= sq_d[1];
      b_sq_q[2] <= sq_d[2];
    end
  end

  // ---------------- stage C: sum, compare, result register ----------------
  logic [DIST_W-1:0] dist_sum;
  logic              keep_d;

  assign dist_sum = DIST_W'(b_sq_q[0]) + DIST_W'(b_sq_q[1]) + DIST_W'(b_sq_q[2]);
  assign keep_d   = b_match_q.shared & (CMP_W'(dist_sum) > CMP_W'(limit_q));

  logic       c_shared_q;
  logic [1:0] c_cur_edge_q;
  logic [1:0] c_oth_edge_q;
  logic       c_keep_q;

  always_ff @(posedge clk_i) begin
    if (b_valid_q && c_ready) begin
      c_shared_q   <= b_match_q.shared;
      c_cur_edge_q <= b_match_q.cur_edge;
      c_oth_edge_q <= b_match_q.oth_edge;
      c_keep_q     <= keep_d;
    end
  end

  assign out_valid_o      = c_valid_q;
  assign edge_shared_o    = c_shared_q;
  assign cur_edge_index_o = c_cur_edge_q;
  assign oth_edge_index_o = c_oth_edge_q;
  assign cur_edge_keep_o  = c_keep_q;
  assign oth_edge_clear_o = c_keep_q;

endmodule

FILE: rtl/secc_edge_match.sv
// Vertex matching and shared edge decode for one triangle pair.
// Depends on secc_pkg for the edge codes and the match struct.
`timescale 1ns / 1ps

module secc_edge_match #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic [secc_pkg::FIELD_W-1:0] cur_v0_i,
  input  logic [secc_pkg::FIELD_W-1:0] cur_v1_i,
  input  logic [secc_pkg::FIELD_W-1:0] cur_v2_i,
  input  logic [secc_pkg::FIELD_W-1:0] oth_v0_i,
  input  logic [secc_pkg::FIELD_W-1:0] oth_v1_i,
  input  logic [secc_pkg::FIELD_W-1:0] oth_v2_i,
  output secc_pkg::match_t             match_o
);

  // Only the packed coordinate bits take part in the compare.
  localparam int unsigned VCODE_W =
    (3 * COORD_BITS < secc_pkg::FIELD_W) ? 3 * COORD_BITS : secc_pkg::FIELD_W;

  logic [VCODE_W-1:0] cur_code [3];
  logic [VCODE_W-1:0] oth_code [3];
  logic [2:0]         found;
  logic [2:0]         oth_mask;
  secc_pkg::edge_dec_t cur_dec;
  secc_pkg::edge_dec_t oth_dec;

  assign cur_code[0] = cur_v0_i[VCODE_W-1:0];
  assign cur_code[1] = cur_v1_i[VCODE_W-1:0];
  assign cur_code[2] = cur_v2_i[VCODE_W-1:0];
  assign oth_code[0] = oth_v0_i[VCODE_W-1:0];
  assign oth_code[1] = oth_v1_i[VCODE_W-1:0];
  assign oth_code[2] = oth_v2_i[VCODE_W-1:0];

  // Each current vertex marks the first equal vertex of the other face.
  always_comb begin
    found    = '0;
    oth_mask = '0;
    for (int i = 0; i < 3; i++) begin
      if (cur_code[i] == oth_code[0]) begin
        found[i]    = 1'b1;
        oth_mask[0] = 1'b1;
      end else if (cur_code[i] == oth_code[1]) begin
        found[i]    = 1'b1;
        oth_mask[1] = 1'b1;
      end else if (cur_code[i] == oth_code[2]) begin
        found[i]    = 1'b1;
        oth_mask[2] = 1'b1;
      end
    end
  end

  // Two hits on the same other vertex leave a single bit: no edge.
  assign cur_dec = secc_pkg::edge_from_mask(found);
  assign oth_dec = secc_pkg::edge_from_mask(oth_mask);

  always_comb begin
    match_o.shared   = cur_dec.valid & oth_dec.valid;
    match_o.cur_edge = match_o.shared ? cur_dec.code : secc_pkg::EDGE_01;
    match_o.oth_edge = match_o.shared ? oth_dec.code : secc_pkg::EDGE_01;
  end

endmodule

FILE: test/tb_shared_edge_crease_classifier.sv
// Self-checking testbench for shared_edge_crease_classifier: random and directed triangle pairs,
// crease limit swept over the APB port, results checked in order against a local predictor.
// Depends on secc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_shared_edge_crease_classifier;

  localparam int CB          = 16;   // coordinate code width
  localparam int NB          = 16;   // normal component width
  localparam int PIPE_LAT    = 3;
  localparam int GAP_PCT     = 27;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_LEN    = 120;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [secc_pkg::FIELD_W-1:0] field_t;

  typedef struct packed {
    logic [2:0][secc_pkg::FIELD_W-1:0] cur_v;
    logic [2:0][secc_pkg::FIELD_W-1:0] oth_v;
    field_t                            cur_n;
    field_t                            oth_n;
  } face_pair_t;

  typedef struct packed {
    logic                shared;
    secc_pkg::edge_idx_e cur_e;
    secc_pkg::edge_idx_e oth_e;
    logic                keep;
    logic                clear;
  } crease_res_t;

  logic                         clk_i   = 1'b0;
  logic                         rst_ni  = 1'b0;
  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [secc_pkg::PADDR_W-1:0] paddr   = '0;
  logic [secc_pkg::PDATA_W-1:0] pwdata  = '0;
  logic [secc_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  logic   in_valid_i = 1'b0;
  logic   in_stall_o;
  field_t cur_vertex_a_i = '0, cur_vertex_b_i = '0, cur_vertex_c_i = '0;
  field_t oth_vertex_a_i = '0, oth_vertex_b_i = '0, oth_vertex_c_i = '0;
  field_t cur_unit_normal_i = '0, oth_unit_normal_i = '0;

  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       edge_shared_o;
  logic [1:0] cur_edge_index_o;
  logic [1:0] oth_edge_index_o;
  logic       cur_edge_keep_o;
  logic       oth_edge_clear_o;

  shared_edge_crease_classifier DUT (.*);

  face_pair_t                   pair_q[$];
  crease_res_t                  verdict_q[$];
  face_pair_t                   offered;
  logic [secc_pkg::LIMIT_W-1:0] limit_sq = secc_pkg::LIMIT_RESET;
  int                           gap_pct = GAP_PCT;
  int                           n_accepted = 0;
  int                           n_results = 0, n_shared = 0, n_kept = 0;
  int                           n_mismatch = 0, n_orphan = 0, n_settings = 0;
  int                           hold_left = 0;
  logic                         hold_done = 1'b0;
  int                           cycle_cnt = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still due", cycle_cnt, verdict_q.size());
    $display("shared_edge_crease_classifier test failed");
    $finish;
  end

  function automatic field_t rand_field();
    return field_t'({$urandom, $urandom});
  endfunction

  function automatic field_t pack_normal(int x, int y, int z);
    return {z[NB-1:0], y[NB-1:0], x[NB-1:0]};
  endfunction

  function automatic face_pair_t pair_of(field_t c0, field_t c1, field_t c2,
                                         field_t o0, field_t o1, field_t o2,
                                         field_t cn, field_t on);
    face_pair_t t;
    t.cur_v[0] = c0; t.cur_v[1] = c1; t.cur_v[2] = c2;
    t.oth_v[0] = o0; t.oth_v[1] = o1; t.oth_v[2] = o2;
    t.cur_n = cn;
    t.oth_n = on;
    return t;
  endfunction

  function automatic secc_pkg::edge_idx_e edge_code(int p, int q);
    int lo;
    int hi;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    if (lo == 0 && hi == 1) return secc_pkg::EDGE_01;
    if (lo == 1 && hi == 2) return secc_pkg::EDGE_12;
    return secc_pkg::EDGE_02;
  endfunction

  // Expected result for one triangle pair under the given limit.
  function automatic crease_res_t classify_pair(face_pair_t t,
                                                logic [secc_pkg::LIMIT_W-1:0] lim);
    crease_res_t r;
    int          hits;
    int          cpos[2];
    int          opos[2];
    logic        found;
    longint      d;
    longint      dsum;
    r = '0;
    hits = 0;
    cpos[0] = 0; cpos[1] = 0; opos[0] = 0; opos[1] = 0;
    for (int i = 0; i < 3; i++) begin
      found = 1'b0;
      for (int j = 0; j < 3; j++) begin
        if (!found && t.cur_v[i][3*CB-1:0] == t.oth_v[j][3*CB-1:0]) begin
          found = 1'b1;
          if (hits < 2) begin
            cpos[hits] = i;
            opos[hits] = j;
          end
          hits++;
        end
      end
    end
    // no shared edge: not exactly two hits, or two current vertices landed on one vertex of the other face
    if (hits != 2 || opos[0] == opos[1]) return r;
    dsum = 0;
    for (int k = 0; k < 3; k++) begin
      d = longint'($signed(t.cur_n[k*NB +: NB])) - longint'($signed(t.oth_n[k*NB +: NB]));
      dsum += d * d;
    end
    r.shared = 1'b1;
    r.cur_e  = edge_code(cpos[0], cpos[1]);
    r.oth_e  = edge_code(opos[0], opos[1]);
    r.keep   = dsum > longint'(lim);
    r.clear  = r.keep;
    return r;
  endfunction

  // Small signed nudge per component, span picked at random so distances land on both sides.
  function automatic field_t nudge(field_t n);
    field_t o;
    int     span;
    int     delta;
    for (int k = 0; k < 3; k++) begin
      span = (1 << $urandom_range(15)) - 1;
      delta = int'($urandom_range(2 * span)) - span;
      o[k*NB +: NB] = n[k*NB +: NB] + delta[NB-1:0];
    end
    return o;
  endfunction

  function automatic field_t corner_normal();
    field_t o;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(4))
        0: o[k*NB +: NB] = 16'h8000;
        1: o[k*NB +: NB] = 16'h7fff;
        2: o[k*NB +: NB] = 16'h0000;
        3: o[k*NB +: NB] = 16'hffff;
        default: o[k*NB +: NB] = 16'($urandom);
      endcase
    end
    return o;
  endfunction

  function automatic face_pair_t make_pair();
    face_pair_t t;
    field_t     flip;
    int         kind, p, q, r, s, u;
    for (int i = 0; i < 3; i++) begin
      t.cur_v[i] = rand_field();
      t.oth_v[i] = rand_field();
    end
    p = $urandom_range(2);
    q = (p + 1 + $urandom_range(1)) % 3;
    r = $urandom_range(2);
    s = (r + 1 + $urandom_range(1)) % 3;
    u = 3 - r - s;
    flip = '0;
    flip[$urandom_range(secc_pkg::FIELD_W-1)] = 1'b1;
    kind = $urandom_range(99);
    if (kind < 60) begin
      t.oth_v[r] = t.cur_v[p];
      t.oth_v[s] = t.cur_v[q];
      if ($urandom_range(19) == 0) t.oth_v[u] = t.cur_v[3-p-q];
    end else if (kind < 68) begin
      t.oth_v[r] = t.cur_v[p];
    end else if (kind < 76) begin
      t.oth_v[r] = t.cur_v[p];
      t.oth_v[s] = t.cur_v[q];
      t.oth_v[u] = t.cur_v[3-p-q];
    end else if (kind < 83) begin
      t.cur_v[q] = t.cur_v[p];
      t.oth_v[r] = t.cur_v[p];
    end else if (kind < 90) begin
      // repeated vertex in the other face: first match wins
      t.oth_v[r] = t.cur_v[p];
      t.oth_v[s] = t.cur_v[p];
      t.oth_v[u] = t.cur_v[q];
    end else if (kind < 95) begin
      t.oth_v[r] = t.cur_v[p] ^ flip;
      t.oth_v[s] = t.cur_v[q];
    end
    kind = $urandom_range(99);
    if (kind < 50) begin
      t.cur_n = rand_field();
      t.oth_n = nudge(t.cur_n);
    end else if (kind < 80) begin
      t.cur_n = rand_field();
      t.oth_n = rand_field();
    end else begin
      t.cur_n = corner_normal();
      t.oth_n = corner_normal();
    end
    return t;
  endfunction

  // Sender: hold the payload while stalled, otherwise offer the next item or idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        verdict_q.push_back(classify_pair(offered, limit_sq));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pair_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          offered = pair_q.pop_front();
          cur_vertex_a_i    <= offered.cur_v[0];
          cur_vertex_b_i    <= offered.cur_v[1];
          cur_vertex_c_i    <= offered.cur_v[2];
          oth_vertex_a_i    <= offered.oth_v[0];
          oth_vertex_b_i    <= offered.oth_v[1];
          oth_vertex_c_i    <= offered.oth_v[2];
          cur_unit_normal_i <= offered.cur_n;
          oth_unit_normal_i <= offered.oth_n;
          in_valid_i        <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, so the pipeline fills and pushes back.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // Receiver: check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    crease_res_t want;
    crease_res_t got;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got.shared = edge_shared_o;
        got.cur_e  = secc_pkg::edge_idx_e'(cur_edge_index_o);
        got.oth_e  = secc_pkg::edge_idx_e'(oth_edge_index_o);
        got.keep   = cur_edge_keep_o;
        got.clear  = oth_edge_clear_o;
        if (verdict_q.size() == 0) begin
          n_orphan++;
          if (n_orphan + n_mismatch <= 10)
            $display("result with nothing due: shared=%0b cur=%0d oth=%0d keep=%0b clear=%0b",
                     got.shared, got.cur_e, got.oth_e, got.keep, got.clear);
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            n_mismatch++;
            if (n_orphan + n_mismatch <= 10)
              $display("result %0d: want shared=%0b cur=%0d oth=%0d keep=%0b clear=%0b, got %0b %0d %0d %0b %0b",
                       n_results, want.shared, want.cur_e, want.oth_e, want.keep, want.clear,
                       got.shared, got.cur_e, got.oth_e, got.keep, got.clear);
          end
          if (want.shared) n_shared++;
          if (want.keep) n_kept++;
        end
        n_results++;
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < gap_pct);
    end
  end

  task automatic write_limit(logic [secc_pkg::PDATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= secc_pkg::PADDR_W'(8 * int'(secc_pkg::REG_CREASE_LIMIT_SQ));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    limit_sq = value[secc_pkg::LIMIT_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_settings++;
  endtask

  // Wait until every item is in and every result is out, then let the pipe settle.
  task automatic drain();
    do @(negedge clk_i);
    while (pair_q.size() != 0 || in_valid_i || verdict_q.size() != 0);
    repeat (PIPE_LAT + 2) @(negedge clk_i);
  endtask

  task automatic push_random(int count);
    repeat (count) pair_q.push_back(make_pair());
  endtask

  initial begin
    field_t va, vb, vc, vd, ve, nn;
    field_t ones;
    int     n_fail;
    ones = '1;
    va = rand_field(); vb = rand_field(); vc = rand_field();
    vd = rand_field(); ve = rand_field(); nn = rand_field();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset limit.
    pair_q.push_back(pair_of('0, '0, '0, '0, '0, '0, '0, '0));
    pair_q.push_back(pair_of(ones, ones, ones, ones, ones, ones, ones, ones));
    pair_q.push_back(pair_of(va, vb, vc, va, vb, vd, nn, nn));
    pair_q.push_back(pair_of(va, vb, vc, vc, vd, vb,
                             pack_normal(-32768, -32768, -32768), pack_normal(32767, 32767, 32767)));
    pair_q.push_back(pair_of(va, vb, vc, vd, va, vc, rand_field(), rand_field()));
    pair_q.push_back(pair_of(va, vb, vc, va, vd, ve, nn, nn));
    pair_q.push_back(pair_of(ones, ones ^ 48'd1, ones ^ 48'd2, '0, 48'd1, 48'd2, ones, '0));
    pair_q.push_back(pair_of(va, va, vc, va, vd, ve, nn, nn));
    pair_q.push_back(pair_of(va, vb, vc, vc, va, vb, nn, nn));
    pair_q.push_back(pair_of(va, vb, vc, va, va, vb, nn, rand_field()));
    pair_q.push_back(pair_of(va, vb, vc, vb, va, vd, {3{16'h5555}}, {3{16'haaaa}}));
    pair_q.push_back(pair_of(va, vb, vc, va ^ 48'h8000_0000_0000, vb, vd, nn, nn));
    pair_q.push_back(pair_of(va, vb, vc, va ^ 48'd1, vb, vd, nn, nn));
    pair_q.push_back(pair_of(va, vb, vc, vb, vc, vd, pack_normal(0, 0, 0),
                             pack_normal(16961, 0, 0)));
    pair_q.push_back(pair_of(va, vb, vc, vb, vc, vd, pack_normal(0, 0, 0),
                             pack_normal(16962, 0, 0)));
    push_random(500);
    drain();

    write_limit('0);
    pair_q.push_back(pair_of(va, vb, vc, vd, vb, va, nn, nn));
    pair_q.push_back(pair_of(va, vb, vc, vd, vb, va, pack_normal(5, 5, 5), pack_normal(5, 5, 6)));
    push_random(300);
    drain();

    // Upper bits beyond the register width are dropped.
    write_limit('1);
    push_random(250);
    drain();

    write_limit(64'd12884508675);
    pair_q.push_back(pair_of(va, vb, vc, va, vc, vd,
                             pack_normal(-32768, -32768, -32768), pack_normal(32767, 32767, 32767)));
    drain();
    write_limit(64'd12884508674);
    pair_q.push_back(pair_of(va, vb, vc, va, vc, vd,
                             pack_normal(-32768, -32768, -32768), pack_normal(32767, 32767, 32767)));
    drain();
    write_limit(64'd12884901888);
    push_random(100);
    drain();

    // No idling on either side for this stretch.
    gap_pct = 0;
    write_limit(64'd10000);
    pair_q.push_back(pair_of(va, vb, vc, vc, vb, vd, pack_normal(0, 0, 0), pack_normal(0, 100, 0)));
    pair_q.push_back(pair_of(va, vb, vc, vc, vb, vd, pack_normal(0, 0, 0), pack_normal(0, 0, -101)));
    push_random(350);
    drain();

    gap_pct = GAP_PCT;
    write_limit(64'hABCD_0000_0000_0000 | 64'(secc_pkg::LIMIT_RESET));
    push_random(350);
    drain();

    n_fail = n_mismatch + n_orphan + verdict_q.size();
    if (verdict_q.size() != 0)
      $display("%0d expected results never arrived", verdict_q.size());
    $display("covered %0d triangle pairs over %0d crease limit settings, %0d results checked",
             n_accepted, n_settings, n_results);
    $display("%0d pairs shared an edge, %0d kept as creases, %0d mismatches",
             n_shared, n_kept, n_mismatch + n_orphan);
    if (n_fail == 0) begin
      $display("shared_edge_crease_classifier test passed");
    end else begin
      $display("shared_edge_crease_classifier test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/secc_pkg.sv
rtl/secc_edge_match.sv
rtl/shared_edge_crease_classifier.sv
test/tb_shared_edge_crease_classifier.sv
